// ===== design/bqdp_pkg.sv =====
// Shared constants, types and weight code helpers for the block quantized dot product.
package bqdp_pkg;

  localparam int LANES     = 4;
  localparam int BYTE_W    = 8;
  localparam int CODE_W    = 8;
  localparam int SCALE_W   = 16;
  localparam int BIAS_W    = 32;
  localparam int ACC_W     = 56;
  localparam int LCNT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE = 2'd1;

  // Weight code width selector values; the unused code behaves as 8-bit codes.
  localparam logic [1:0] WB_2BIT = 2'd0;
  localparam logic [1:0] WB_4BIT = 2'd1;
  localparam logic [1:0] WB_8BIT = 2'd2;

  // One classified item handed from the front to the accumulator.
  typedef struct packed {
    logic signed [ACC_W-1:0]  add;
    logic signed [BIAS_W-1:0] bias;
    logic                     first;
    logic                     last;
  } bqdp_op_t;

  // Codes held in one weight byte.
  function automatic logic [LCNT_W-1:0] codes_per_byte(logic [1:0] wb);
    logic [LCNT_W-1:0] n;
    case (wb)
      WB_2BIT: n = 3'd4;
      WB_4BIT: n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // Signed code of one lane after removing the zero point. Subtracting
  // 2^(bits-1) from an unsigned code is the same as flipping its top bit.
  function automatic logic signed [CODE_W-1:0] lane_code(logic [BYTE_W-1:0] b,
                                                         logic [1:0] wb,
                                                         logic [1:0] lane);
    logic [1:0]               c2;
    logic [3:0]               c4;
    logic signed [CODE_W-1:0] r;
    c2 = 2'(b >> {lane, 1'b0});
    c4 = 4'(b >> {lane[0], 2'b00});
    case (wb)
      WB_2BIT: r = {{7{~c2[1]}}, c2[0]};
      WB_4BIT: r = {{5{~c4[3]}}, c4[2:0]};
      default: r = {~b[7], b[6:0]};
    endcase
    return r;
  endfunction

endpackage

// ===== design/bqdp_if.sv =====
// Valid/ready channel interfaces for input items, results and configuration writes.
interface bqdp_in_if #(
  parameter int ACT_WIDTH = 16
);
  import bqdp_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [BYTE_W-1:0]           weight_byte;
  logic signed [ACT_WIDTH-1:0] act_lane0;
  logic signed [ACT_WIDTH-1:0] act_lane1;
  logic signed [ACT_WIDTH-1:0] act_lane2;
  logic signed [ACT_WIDTH-1:0] act_lane3;
  logic [LCNT_W-1:0]           valid_lanes;
  logic signed [SCALE_W-1:0]   block_scale;
  logic signed [BIAS_W-1:0]    bias_value;
  logic                        first_element;
  logic                        last_element;

  modport source (
    output valid, weight_byte, act_lane0, act_lane1, act_lane2, act_lane3,
           valid_lanes, block_scale, bias_value, first_element, last_element,
    input  ready
  );
  modport sink (
    input  valid, weight_byte, act_lane0, act_lane1, act_lane2, act_lane3,
           valid_lanes, block_scale, bias_value, first_element, last_element,
    output ready
  );
endinterface

interface bqdp_out_if;
  import bqdp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] dot_sum;

  modport source (output valid, dot_sum, input ready);
  modport sink (input valid, dot_sum, output ready);
endinterface

interface bqdp_cfg_if;
  import bqdp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bqdp_front.sv =====
// Front end: configuration registers, code unpacking and the pipelined lane products.
module bqdp_front #(
  parameter int ACT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bqdp_cfg_if.sink          cfg_i,
  bqdp_in_if.sink           in_i,
  output bqdp_pkg::bqdp_op_t op_o,
  output logic              op_valid_o,
  input  logic              op_ready_i
);
  import bqdp_pkg::*;

  localparam int P1W = ACT_WIDTH + CODE_W;
  localparam int P2W = P1W + SCALE_W;
  localparam int SUMW = P2W + 2;

  logic [1:0] weight_bits_q;
  logic       bias_enable_q;

  logic signed [ACT_WIDTH-1:0] acts [LANES];
  logic signed [P1W-1:0]       p1_d [LANES];
  logic signed [P1W-1:0]       p1_q [LANES];
  logic signed [SCALE_W-1:0]   scale_q;
  logic signed [BIAS_W-1:0]    bias1_q, bias2_q;
  logic                        first1_q, first2_q, last1_q, last2_q;
  logic signed [P2W-1:0]       p2_d [LANES];
  logic signed [P2W-1:0]       p2_q [LANES];
  logic signed [SUMW-1:0]      sum_d;
  logic                        s1_valid_q, s2_valid_q, s3_valid_q;
  bqdp_op_t                    s3_q;
  logic                        adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_bits_q <= WB_4BIT;
      bias_enable_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WEIGHT_BITS: weight_bits_q <= cfg_i.data;
        REG_BIAS_ENABLE: bias_enable_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // The three stages move together; they stall only when the last one
  // cannot hand its item to the queue.
  assign adv        = !s3_valid_q || op_ready_i;
  assign in_i.ready = adv;

  assign acts[0] = in_i.act_lane0;
  assign acts[1] = in_i.act_lane1;
  assign acts[2] = in_i.act_lane2;
  assign acts[3] = in_i.act_lane3;

  always_comb begin
    logic [LCNT_W-1:0] per_byte;
    per_byte = codes_per_byte(weight_bits_q);
    for (int i = 0; i < LANES; i++) begin
      if ((LCNT_W'(i) < in_i.valid_lanes) && (LCNT_W'(i) < per_byte)) begin
        p1_d[i] = P1W'(acts[i]) * P1W'(lane_code(in_i.weight_byte, weight_bits_q, 2'(i)));
      end else begin
        p1_d[i] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      p2_d[i] = P2W'(p1_q[i]) * P2W'(scale_q);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_d = sum_d + {{(SUMW-P2W){p2_q[i][P2W-1]}}, p2_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q     <= p1_d;
      scale_q  <= in_i.block_scale;
      bias1_q  <= bias_enable_q ? in_i.bias_value : '0;
      first1_q <= in_i.first_element;
      last1_q  <= in_i.last_element;
      p2_q     <= p2_d;
      bias2_q  <= bias1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      s3_q.add   <= {{(ACC_W-SUMW){sum_d[SUMW-1]}}, sum_d};
      s3_q.bias  <= bias2_q;
      s3_q.first <= first2_q;
      s3_q.last  <= last2_q;
    end
  end

  assign op_o       = s3_q;
  assign op_valid_o = s3_valid_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted item did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !op_ready_i) |=> (s3_valid_q && $stable(s3_q)))
    else $error("stalled item changed before the queue took it");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !op_ready_i) |-> !in_i.ready)
    else $error("item taken while the pipeline is blocked");

endmodule

// ===== design/bqdp_queue.sv =====
// Short queue of classified items between the front end and the accumulator.
module bqdp_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bqdp_pkg::bqdp_op_t push_i,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  output bqdp_pkg::bqdp_op_t pop_o,
  output logic               pop_valid_o,
  input  logic               pop_ready_i
);
  import bqdp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bqdp_op_t         entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not grow on a push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count did not shrink on a pop");

  a_pointers_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ===== design/bqdp_back.sv =====
// Back end: saturating accumulator and the result output register.
module bqdp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bqdp_pkg::bqdp_op_t op_i,
  input  logic               op_valid_i,
  output logic               op_ready_o,
  bqdp_out_if.source         out_o
);
  import bqdp_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W:0]   wide;
  logic signed [ACC_W-1:0] sat;
  logic signed [ACC_W-1:0] dot_q;
  logic                    out_valid_q;
  logic                    take;

  // Items that emit nothing keep flowing while a result waits.
  assign op_ready_o = !op_i.last || !out_valid_q || out_o.ready;
  assign take       = op_valid_i && op_ready_o;

  always_comb begin
    base = op_i.first ? {{(ACC_W-BIAS_W){op_i.bias[BIAS_W-1]}}, op_i.bias} : acc_q;
    wide = {base[ACC_W-1], base} + {op_i.add[ACC_W-1], op_i.add};
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      sat = wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat = wide[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        acc_q <= sat;
      end
      if (take && op_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && op_i.last) begin
      dot_q <= sat;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.dot_sum = dot_q;

  a_emit_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && op_i.last) |=> (out_valid_q && (dot_q == acc_q)))
    else $error("last item did not present its sum");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("waiting result dropped");

  a_acc_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(acc_q))
    else $error("accumulator moved without an item");

endmodule

// ===== design/block_quantized_dot_product_top.sv =====
// Top level of the block quantized dot product.
// Each item carries one packed weight byte (four 2-bit, two 4-bit or one 8-bit
// code), up to four Q7.8 activations, the lane count and the Q3.12 block scale;
// each used lane adds (code - zero point) * activation * scale to a 56-bit
// saturating accumulator with 20 fraction bits. The block takes one item per
// clock cycle while the queue has room: the lane multiplies run in a three-stage
// front pipeline (code times activation, times scale, lane sum), and only the
// accumulate in the back end loops on itself. A queue of QUEUE_DEPTH items parts
// the front from the accumulator, and items that emit nothing pass while a
// result waits to be taken. Configuration writes are always accepted and must
// be made while idle.
module block_quantized_dot_product_top #(
  parameter int ACT_WIDTH   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bqdp_cfg_if.sink   cfg_i,
  bqdp_in_if.sink    in_i,
  bqdp_out_if.source out_o
);
  import bqdp_pkg::*;

  bqdp_op_t front_op, back_op;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;

  bqdp_front #(
    .ACT_WIDTH (ACT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .in_i       (in_i),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .op_ready_i (front_ready)
  );

  bqdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_op),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_o        (back_op),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  bqdp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (back_op),
    .op_valid_i (back_valid),
    .op_ready_o (back_ready),
    .out_o      (out_o)
  );

endmodule

// ===== tb/block_quantized_dot_product_top_test.sv =====
// Self-checking testbench for the block quantized dot product against a cycle-free predictor.
module block_quantized_dot_product_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bqdp_pkg::*;

  localparam longint ACC_MAX = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;
  localparam int LONG_RUN_REPS = 64;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 195;

  typedef struct packed {
    logic [7:0]       weight_byte;
    logic [3:0][15:0] act;
    logic [2:0]       valid_lanes;
    logic [15:0]      block_scale;
    logic [31:0]      bias_value;
    logic             first_element;
    logic             last_element;
  } dot_item_t;

  typedef enum logic [1:0] {ROW_CONFIG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  cfg_bits;
    logic        cfg_bias;
    dot_item_t   item;
    logic [31:0] reps;
    logic        known;
    logic [55:0] known_sum;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bqdp_cfg_if cfg ();
  bqdp_in_if #(.ACT_WIDTH(16)) feed ();
  bqdp_out_if sums ();

  block_quantized_dot_product_top u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .in_i  (feed),
    .out_o (sums)
  );

  always #5 clk = ~clk;

  // Predictor state: the running accumulator and the two registers.
  longint      dot_acc;
  logic [1:0]  wb_setting;
  logic        bias_on;
  logic [55:0] sums_due[$];
  logic [55:0] due_sum;
  int          mismatches;
  bit          no_idle;
  bit          hold_off_req;
  stim_row_t   plan[$];

  function automatic longint accumulate_item(input dot_item_t it);
    int     bits;
    int     per_byte;
    int     n;
    int     code;
    int     i;
    longint total;
    longint start;
    longint acc_next;
    bits = (wb_setting == WB_2BIT) ? 2 : (wb_setting == WB_4BIT) ? 4 : 8;
    per_byte = 8 / bits;
    n = (int'(it.valid_lanes) > per_byte) ? per_byte : int'(it.valid_lanes);
    total = 0;
    for (i = 0; i < n; i++) begin
      code = int'((it.weight_byte >> (i * bits)) & ((1 << bits) - 1)) - (1 << (bits - 1));
      total += longint'($signed(it.act[i])) * code * longint'($signed(it.block_scale));
    end
    if (it.first_element) begin
      start = bias_on ? longint'($signed(it.bias_value)) : 64'sd0;
    end else begin
      start = dot_acc;
    end
    acc_next = start + total;
    if (acc_next > ACC_MAX) acc_next = ACC_MAX;
    if (acc_next < ACC_MIN) acc_next = ACC_MIN;
    dot_acc = acc_next;
    return acc_next;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dot_item_t random_item(input bit first, input bit last);
    dot_item_t it;
    int        lanes_max;
    lanes_max = (wb_setting == WB_2BIT) ? 4 : (wb_setting == WB_4BIT) ? 2 : 1;
    it.weight_byte = 8'($urandom);
    it.act = {pick16(), pick16(), pick16(), pick16()};
    it.valid_lanes = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, lanes_max));
    it.block_scale = pick16();
    case ($urandom_range(0, 7))
      0: it.bias_value = 32'h8000_0000;
      1: it.bias_value = 32'h7FFF_FFFF;
      default: it.bias_value = $urandom;
    endcase
    it.first_element = first;
    it.last_element = last;
    return it;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] bits, input logic bias);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.cfg_bits = bits;
    r.cfg_bias = bias;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [7:0] wbyte, input logic [15:0] a0,
                                         input logic [15:0] a1, input logic [15:0] a2,
                                         input logic [15:0] a3, input logic [2:0] lanes,
                                         input logic [15:0] scale, input logic [31:0] bias,
                                         input bit first, input bit last, input int reps,
                                         input bit known, input logic [55:0] sum);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.weight_byte = wbyte;
    r.item.act = {a3, a2, a1, a0};
    r.item.valid_lanes = lanes;
    r.item.block_scale = scale;
    r.item.bias_value = bias;
    r.item.first_element = first;
    r.item.last_element = last;
    r.reps = reps;
    r.known = known;
    r.known_sum = sum;
    return r;
  endfunction

  // Offers one item, updates the predictor once it is accepted and books the expected sum of a last item.
  task automatic drive_item(input dot_item_t it, input int gap, input bit use_known,
                            input logic [55:0] known_sum);
    longint sum;
    @(negedge clk);
    if (gap > 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed.valid <= 1'b1;
    feed.weight_byte <= it.weight_byte;
    feed.act_lane0 <= it.act[0];
    feed.act_lane1 <= it.act[1];
    feed.act_lane2 <= it.act[2];
    feed.act_lane3 <= it.act[3];
    feed.valid_lanes <= it.valid_lanes;
    feed.block_scale <= it.block_scale;
    feed.bias_value <= it.bias_value;
    feed.first_element <= it.first_element;
    feed.last_element <= it.last_element;
    do @(posedge clk); while (!feed.ready);
    sum = accumulate_item(it);
    if (it.last_element) begin
      sums_due.push_back(use_known ? known_sum : sum[55:0]);
    end
  endtask

  // Items that emit nothing may still be in flight after the last result, so the
  // block is given a settling time before its registers change.
  task automatic settle_block();
    @(negedge clk);
    feed.valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_WEIGHT_BITS) begin
      wb_setting = val;
    end else if (idx == REG_BIAS_ENABLE) begin
      bias_on = val[0];
    end
  endtask

  task automatic program_regs(input logic [1:0] bits, input logic bias);
    cfg_write(REG_WEIGHT_BITS, bits);
    cfg_write(REG_BIAS_ENABLE, {1'b0, bias});
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && sums.valid && sums.ready) begin
      if (sums_due.size() == 0) begin
        $display("%0t ns: expected no result, got dot_sum %0d", $time, $signed(sums.dot_sum));
        mismatches++;
      end else begin
        due_sum = sums_due.pop_front();
        if (sums.dot_sum !== due_sum) begin
          $display("%0t ns: dot_sum expected %0d, got %0d", $time, $signed(due_sum),
                   $signed(sums.dot_sum));
          mismatches++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    sums.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        sums.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        sums.ready <= 1'b0;
        repeat (idle_len() - 1) @(negedge clk);
      end else begin
        sums.ready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    dot_item_t it;
    stim_row_t step_row;
    int        len;
    int        sent;
    int        ph;
    int        r;
    int        k;
    int        gap;
    bit        short_runs;

    rst_n = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    feed.valid = 1'b0;
    feed.weight_byte = '0;
    feed.act_lane0 = '0;
    feed.act_lane1 = '0;
    feed.act_lane2 = '0;
    feed.act_lane3 = '0;
    feed.valid_lanes = '0;
    feed.block_scale = '0;
    feed.bias_value = '0;
    feed.first_element = 1'b0;
    feed.last_element = 1'b0;
    dot_acc = 0;
    wb_setting = WB_4BIT;
    bias_on = 1'b0;
    mismatches = 0;
    no_idle = 1'b0;
    hold_off_req = 1'b0;

    // Directed table. An item row with more than one repeat is sent back to back,
    // first flag on its first copy and last flag on its final copy.
    // Right after reset the accumulator is zero; no lanes, no start item.
    plan.push_back(item_row(8'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 16'h7FFF,
                            32'h7FFF_FFFF, 1'b0, 1'b1, 1, 1'b1, 56'sd0));
    plan.push_back(item_row(8'h00, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 3'd2, 16'h1000,
                            32'h0, 1'b1, 1'b1, 1, 1'b1, -56'sd8388608));
    // Lane count above the codes per byte is capped.
    plan.push_back(item_row(8'hFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd7, 16'h8000,
                            32'h0, 1'b1, 1'b1, 1, 1'b1, 56'sd15032385536));
    // After an emit the sum carries on into items with no start flag.
    plan.push_back(item_row(8'h5A, 16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 3'd3, 16'h0ABC,
                            32'h0, 1'b0, 1'b0, 1, 1'b0, '0));
    plan.push_back(item_row(8'hC3, 16'h8001, 16'h7FFE, 16'h0001, 16'hFFFF, 3'd1, 16'hF123,
                            32'h0, 1'b0, 1'b1, 1, 1'b0, '0));
    plan.push_back(cfg_row(WB_2BIT, 1'b1));
    plan.push_back(item_row(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 16'h7FFF,
                            32'h7FFF_FFFF, 1'b1, 1'b1, 1, 1'b1, 56'sd2147483647));
    plan.push_back(item_row(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 16'h7FFF,
                            32'h8000_0000, 1'b1, 1'b1, 1, 1'b1, -56'sd2147483648));
    plan.push_back(item_row(8'hE4, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 3'd4, 16'h1000,
                            32'h0, 1'b1, 1'b0, 1, 1'b0, '0));
    plan.push_back(item_row(8'h1B, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 3'd7, 16'h1000,
                            32'h0, 1'b0, 1'b1, 1, 1'b1, -56'sd10485760));
    // The unused width selector behaves as 8-bit codes.
    plan.push_back(cfg_row(2'd3, 1'b0));
    plan.push_back(item_row(8'h80, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 3'd4, 16'h7FFF,
                            32'h1234_5678, 1'b1, 1'b1, 1, 1'b1, 56'sd0));
    plan.push_back(item_row(8'h00, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 3'd1, 16'h8000,
                            32'h0, 1'b1, 1'b1, 1, 1'b1, -56'sd137438953472));
    // A long back-to-back run of the largest 8-bit product.
    plan.push_back(cfg_row(WB_8BIT, 1'b0));
    plan.push_back(item_row(8'h00, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 3'd1, 16'h7FFF,
                            32'h0, 1'b1, 1'b1, LONG_RUN_REPS, 1'b0, '0));
    plan.push_back(item_row(8'hFF, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 3'd1, 16'h1000,
                            32'h0, 1'b0, 1'b1, 1, 1'b0, '0));
    plan.push_back(cfg_row(WB_4BIT, 1'b1));
    plan.push_back(item_row(8'hF0, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 3'd2, 16'h7FFF,
                            32'h7FFF_FFFF, 1'b1, 1'b1, 1, 1'b0, '0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < plan.size(); r++) begin
      step_row = plan[r];
      if (step_row.kind == ROW_CONFIG) begin
        settle_block();
        program_regs(step_row.cfg_bits, step_row.cfg_bias);
      end else begin
        for (k = 0; k < int'(step_row.reps); k++) begin
          it = step_row.item;
          it.first_element = step_row.item.first_element && (k == 0);
          it.last_element = step_row.item.last_element && (k == int'(step_row.reps) - 1);
          gap = (step_row.reps > 1 || $urandom_range(0, 2) != 0) ? 0 : idle_len();
          drive_item(it, gap, step_row.known && (k == int'(step_row.reps) - 1),
                     step_row.known_sum);
        end
      end
    end

    // Random dot products with random content, with a little noise mixed in.
    // One phase runs with no idling; another sends very short dot products while
    // the result side holds off, so the block backs up into its input.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle_block();
      program_regs(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      no_idle = (ph == 4);
      short_runs = (ph == 2);
      if (short_runs) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          len = 1;
          it = random_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
          drive_item(it, gap, 1'b0, '0);
        end else begin
          if (short_runs) begin
            len = $urandom_range(1, 2);
          end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
          end
          for (k = 0; k < len; k++) begin
            it = random_item(k == 0, k == len - 1);
            gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
            drive_item(it, gap, 1'b0, '0);
          end
        end
        sent += len;
      end
    end
    no_idle = 1'b0;

    settle_block();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bqdp_pkg.sv
design/bqdp_if.sv
design/bqdp_front.sv
design/bqdp_queue.sv
design/bqdp_back.sv
design/block_quantized_dot_product_top.sv
tb/block_quantized_dot_product_top_test.sv
